/* rtl/core/skbh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skbh_pkg
// Shared types and constants of the string key bucket hash block.
// ----------------------------------------------------------------------------
package skbh_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] count_type;
   typedef logic [31:0] word_type;

   // mixing constants
   localparam word_type MIX_SEED  = 32'h1234_5678;
   localparam word_type MIX_MULT  = 32'h5bd1_e995;
   localparam int       MIX_SHIFT = 15;
   localparam int       HALF_BITS = 16;

   // one remainder bit per step
   localparam int DIV_STEPS = 32;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   typedef logic [STEP_W-1:0] step_type;

   // controller to datapath
   typedef struct packed {
      logic accept;     // take a key byte, start the multiply
      logic mix_step;   // fold the product into the mixing state
      logic div_step;   // one restoring divide step
      logic load_out;   // move the finished hash into the output register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;         // byte in flight ends the key
      logic bucket_zero;  // no reduction wanted
   } dp_status_type;

endpackage

/* rtl/core/skbh_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skbh_req_if
// Key byte channel: valid/ready handshake with one key byte per beat.
// ----------------------------------------------------------------------------
interface skbh_req_if;
   logic               valid;
   logic               ready;
   skbh_pkg::byte_type key_byte;
   logic               end_of_key;

   modport source (output valid, output key_byte, output end_of_key, input ready);
   modport sink   (input valid, input key_byte, input end_of_key, output ready);
endinterface

/* rtl/core/skbh_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skbh_rsp_if
// Hash result channel: valid/ready handshake with one hash word per beat.
// ----------------------------------------------------------------------------
interface skbh_rsp_if;
   logic               valid;
   logic               ready;
   skbh_pkg::word_type hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink   (input valid, input hash_value, output ready);
endinterface

/* rtl/core/skbh_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skbh_datapath
// Mixing state, byte count, multiplier, restoring divider and output register.
// ----------------------------------------------------------------------------
module skbh_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  skbh_pkg::word_type     csr_wr_data,
   input  skbh_pkg::byte_type     key_byte,
   input  logic                   end_of_key,
   input  skbh_pkg::dp_cmd_type   cmd,
   output skbh_pkg::dp_status_type status,
   output skbh_pkg::word_type     hash_value
);
   import skbh_pkg::*;

   word_type  bucket_ff;
   word_type  mix_ff, mix_in;
   count_type count_ff, count_in;
   byte_type  prev_ff;
   logic      in_key_ff;
   logic      last_ff;
   word_type  prod_ff, prod_in;
   logic [15:0] low_ff, low_in;
   word_type  rem_ff, rem_in;
   word_type  quo_ff, quo_in;
   word_type  out_ff;
   word_type  mixed;
   word_type  word;
   byte_type  second_last;
   logic [32:0] shifted;
   logic [32:0] diff;

   // product of the xored state, truncated to 32 bits
   always_comb begin
      prod_in = word_type'(
         (mix_ff ^ {{24{key_byte[7]}}, key_byte}) * MIX_MULT);
   end

   // low half from the last two bytes, the sign of the last byte and the inverted new count
   always_comb begin
      count_in    = count_ff + 16'd1;
      second_last = in_key_ff ? prev_ff : key_byte;
      low_in      = {(key_byte[7] ? 8'hFF : second_last), key_byte} ^ ~count_in;
   end

   // fold and build the unreduced word
   always_comb begin
      mixed  = prod_ff ^ (prod_ff >> MIX_SHIFT);
      word   = {mixed[31:HALF_BITS], low_ff};
      mix_in = mixed;
   end

   // one restoring divide step
   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      diff    = shifted - {1'b0, bucket_ff};
      rem_in  = diff[32] ? shifted[31:0] : diff[31:0];
      quo_in  = {quo_ff[30:0], 1'b0};
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_ff <= '0;
      end else if (csr_wr_en) begin
         bucket_ff <= csr_wr_data;
      end
   end

   // key state
   always_ff @(posedge clock) begin
      if (reset) begin
         mix_ff    <= MIX_SEED;
         count_ff  <= '0;
         prev_ff   <= '0;
         in_key_ff <= 1'b0;
      end else if (cmd.accept) begin
         count_ff  <= count_in;
         prev_ff   <= key_byte;
         in_key_ff <= 1'b1;
      end else if (cmd.mix_step) begin
         if (last_ff) begin
            mix_ff    <= MIX_SEED;
            count_ff  <= '0;
            in_key_ff <= 1'b0;
         end else begin
            mix_ff <= mix_in;
         end
      end
   end

   // per-beat payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         prod_ff <= prod_in;
         low_ff  <= low_in;
         last_ff <= end_of_key;
      end
   end

   // divider registers, loaded with the word at the end of a key
   always_ff @(posedge clock) begin
      if (cmd.mix_step && last_ff) begin
         if (bucket_ff == '0) begin
            rem_ff <= word;
         end else begin
            rem_ff <= '0;
            quo_ff <= word;
         end
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_ff <= rem_ff;
      end
   end

   assign status.last        = last_ff;
   assign status.bucket_zero = (bucket_ff == '0);
   assign hash_value         = out_ff;

endmodule

/* rtl/core/skbh_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skbh_ctrl
// Sequencer for byte mixing, the divide loop and the output beat.
// ----------------------------------------------------------------------------
module skbh_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  skbh_pkg::dp_status_type status,
   output skbh_pkg::dp_cmd_type    cmd
);
   import skbh_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MIX  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_HOLD = 2'd3;

   logic [1:0] state_ff, state_in;
   step_type   step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_MIX;
            end
         end
         S_MIX: begin
            cmd.mix_step = 1'b1;
            step_in      = '0;
            if (!status.last) begin
               state_in = S_IDLE;
            end else if (status.bucket_zero) begin
               state_in = S_HOLD;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == step_type'(DIV_STEPS - 1)) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output valid flag
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

/* rtl/core/string_key_bucket_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_key_bucket_hash
// Byte-serial string key hash with optional reduction to a bucket index.
// ----------------------------------------------------------------------------
// A key arrives one byte per beat with end_of_key on its final byte, and each
// byte passes through the 32x32 multiplier, then a fold of the product back
// into the mixing state. The final byte then yields one hash word: with
// bucket_count zero it goes to the output register unreduced, otherwise a
// restoring divider first reduces it, one remainder bit per cycle. The
// finished word sits in an output register, and the next key's bytes are
// taken while it waits for the sink.
// Write bucket_count only while no key is in flight.
module string_key_bucket_hash (
   input  logic               clock,
   input  logic               reset,
   skbh_req_if.sink           req_ch,
   skbh_rsp_if.source         rsp_ch,
   input  logic               csr_wr_en,
   input  skbh_pkg::word_type csr_wr_data
);
   import skbh_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   skbh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   skbh_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .key_byte    (req_ch.key_byte),
      .end_of_key  (req_ch.end_of_key),
      .cmd         (cmd),
      .status      (status),
      .hash_value  (rsp_ch.hash_value)
   );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the string key bucket hash block.
// ----------------------------------------------------------------------------
// Keys are streamed one byte per beat under random valid and ready gaps. A
// software copy of the mixing hash runs on every accepted key beat and queues
// the hash word due on each final byte. Every hash beat is compared against
// the oldest queued word. The bucket count is rewritten between phases while
// the block is idle: all-ones, one, 2^31, 97, two random moduli, zero and 1000.
// One quiet phase runs keys back to back with no stalls on either side.
// ----------------------------------------------------------------------------
module tb_top;
   import skbh_pkg::*;

   typedef struct {
      byte_type key_byte;
      logic     end_of_key;
   } key_beat_type;

   // enough for the divider plus the output register
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_PCT     = 28;

   logic     clock;
   logic     reset;
   logic     csr_wr_en;
   word_type csr_wr_data;

   skbh_req_if key_ch ();
   skbh_rsp_if hash_ch ();

   string_key_bucket_hash dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (key_ch),
      .rsp_ch      (hash_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   key_beat_type pending_beats[$];
   word_type     expected_hashes[$];
   int           beats_queued = 0;
   int           beats_taken  = 0;
   int           fail_count   = 0;
   bit           no_stall     = 1'b0;
   bit           beat_taken   = 1'b0;

   // shadow of the hashing state
   word_type  mix_acc;
   byte_type  prior_byte;
   count_type key_len;
   bit        key_open;
   word_type  bucket_mod;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop
   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic word_type mix_in(word_type h, byte_type b);
      h = h ^ {{24{b[7]}}, b};
      h = h * MIX_MULT;
      return h ^ (h >> MIX_SHIFT);
   endfunction

   // advance the shadow state by one key byte, return 1 when a hash is due
   function automatic bit hash_beat(byte_type b, logic last, output word_type hash);
      byte_type  second;
      logic [15:0] low;
      second     = key_open ? prior_byte : b;
      mix_acc    = mix_in(mix_acc, b);
      key_len    = key_len + 16'd1;
      prior_byte = b;
      key_open   = 1'b1;
      hash       = '0;
      if (!last)
         return 1'b0;
      low  = {second | {8{b[7]}}, b} ^ ~key_len;
      hash = {mix_acc[31:HALF_BITS], low};
      if (bucket_mod != 0)
         hash = hash % bucket_mod;
      mix_acc  = MIX_SEED;
      key_len  = '0;
      key_open = 1'b0;
      return 1'b1;
   endfunction

   task automatic log_failure(string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // key beat driver
   always @(negedge clock) begin
      key_beat_type beat;
      if (reset) begin
         key_ch.valid <= 1'b0;
      end else if (!key_ch.valid || beat_taken) begin
         if (pending_beats.size() != 0 && (no_stall || $urandom_range(99) >= STALL_PCT)) begin
            beat = pending_beats.pop_front();
            key_ch.valid      <= 1'b1;
            key_ch.key_byte   <= beat.key_byte;
            key_ch.end_of_key <= beat.end_of_key;
         end else begin
            key_ch.valid <= 1'b0;
         end
      end
   end

   // hash sink backpressure
   always @(negedge clock) begin
      hash_ch.ready <= no_stall || ($urandom_range(99) >= STALL_PCT);
   end

   // monitor: predict on key beats, check hash beats
   always @(posedge clock) begin
      word_type want;
      beat_taken <= !reset && key_ch.valid && key_ch.ready;
      if (!reset) begin
         if (key_ch.valid && key_ch.ready) begin
            beats_taken++;
            if (hash_beat(key_ch.key_byte, key_ch.end_of_key, want))
               expected_hashes.push_back(want);
         end
         if (hash_ch.valid && hash_ch.ready) begin
            if (expected_hashes.size() == 0) begin
               log_failure($sformatf("hash %08h with none expected", hash_ch.hash_value));
            end else begin
               want = expected_hashes.pop_front();
               if (hash_ch.hash_value !== want)
                  log_failure($sformatf("hash_value expected %08h actual %08h",
                                        want, hash_ch.hash_value));
            end
         end
      end
   end

   task automatic add_beat(byte_type b, logic last);
      key_beat_type beat;
      beat.key_byte   = b;
      beat.end_of_key = last;
      pending_beats.push_back(beat);
      beats_queued++;
   endtask

   // bias toward the sign boundary and the zero byte
   function automatic byte_type pick_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hff;
         2: return 8'h80;
         3: return 8'h7f;
         default: return byte_type'($urandom);
      endcase
   endfunction

   task automatic add_key(int len);
      for (int i = 0; i < len; i++)
         add_beat(pick_byte(), i == len - 1);
   endtask

   // drain everything, then let the divider settle
   task automatic wait_idle();
      while (beats_taken != beats_queued || expected_hashes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_bucket(word_type value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      bucket_mod  = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // stimulus
   initial begin
      word_type bucket_list[7];
      int       phase_bytes;
      int       len;

      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      key_ch.valid       = 1'b0;
      key_ch.key_byte    = '0;
      key_ch.end_of_key  = 1'b0;
      hash_ch.ready      = 1'b0;
      mix_acc            = MIX_SEED;
      prior_byte         = '0;
      key_len            = '0;
      key_open           = 1'b0;
      bucket_mod         = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed keys at the reset modulus of zero
      add_beat(8'h00, 1'b1);
      add_beat(8'hff, 1'b1);
      add_beat(8'h80, 1'b1);
      add_beat(8'h7f, 1'b1);
      add_beat(8'h01, 1'b1);
      add_beat(8'h00, 1'b0);
      add_beat(8'h00, 1'b1);
      add_beat(8'h41, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'h42, 1'b1);
      add_beat(8'hff, 1'b0);
      add_beat(8'h80, 1'b0);
      add_beat(8'h7f, 1'b0);
      add_beat(8'h01, 1'b1);
      add_beat(8'h80, 1'b0);
      add_beat(8'h80, 1'b1);
      add_beat(8'h7f, 1'b0);
      add_beat(8'hff, 1'b1);
      wait_idle();

      // random keys over a range of moduli
      bucket_list[0] = 32'hffff_ffff;
      bucket_list[1] = 32'd1;
      bucket_list[2] = 32'h8000_0000;
      bucket_list[3] = 32'd97;
      bucket_list[4] = word_type'($urandom_range(4096, 2));
      bucket_list[5] = word_type'($urandom);
      bucket_list[6] = '0;
      foreach (bucket_list[p]) begin
         write_bucket(bucket_list[p]);
         phase_bytes = 0;
         while (phase_bytes < 140) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
            add_key(len);
            phase_bytes += len;
         end
         wait_idle();
      end

      // quiet stretch: back-to-back keys with no stalls on either side
      no_stall = 1'b1;
      write_bucket(32'd1000);
      phase_bytes = 0;
      while (phase_bytes < 150) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
         add_key(len);
         phase_bytes += len;
      end
      wait_idle();
      no_stall = 1'b0;

      foreach (expected_hashes[i])
         log_failure($sformatf("hash %08h never arrived", expected_hashes[i]));

      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
